>>> rtl/rpcd_pkg.sv
// ----------------------------------------------------------------------------
// rpcd_pkg
// Shared widths, character codes, register indexes and types of the remote
// pad command decoder.
// ----------------------------------------------------------------------------
package rpcd_pkg;

    localparam int BYTE_W     = 8;
    localparam int DIST_W     = 13;
    localparam int STEP_W     = 6;
    localparam int SPEED_W    = 7;
    localparam int STEER_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // frame characters
    localparam logic [BYTE_W-1:0] CH_START = 8'h21;  // '!'
    localparam logic [BYTE_W-1:0] CH_KIND  = 8'h42;  // 'B'
    localparam logic [BYTE_W-1:0] CH_PRESS = 8'h31;  // hit byte of a press

    // button ids
    localparam logic [BYTE_W-1:0] BTN_UP      = 8'h31;
    localparam logic [BYTE_W-1:0] BTN_DOWN    = 8'h32;
    localparam logic [BYTE_W-1:0] BTN_LAMP    = 8'h33;
    localparam logic [BYTE_W-1:0] BTN_HORN    = 8'h34;
    localparam logic [BYTE_W-1:0] BTN_FORWARD = 8'h35;
    localparam logic [BYTE_W-1:0] BTN_LEFT    = 8'h37;
    localparam logic [BYTE_W-1:0] BTN_RIGHT   = 8'h38;

    localparam logic [SPEED_W-1:0] SPEED_MAX = 7'd100;

    localparam logic [STEER_W-1:0] STEER_RIGHT  = 2'd0;
    localparam logic [STEER_W-1:0] STEER_CENTRE = 2'd1;
    localparam logic [STEER_W-1:0] STEER_LEFT   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DISTANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CEILING = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FLOOR   = 2'd3;

    // reset values
    localparam logic [DIST_W-1:0]  RST_STOP_DISTANCE = 13'd100;
    localparam logic [STEP_W-1:0]  RST_SPEED_STEP    = 6'd6;
    localparam logic [SPEED_W-1:0] RST_SPEED_CEILING = 7'd30;
    localparam logic [SPEED_W-1:0] RST_SPEED_FLOOR   = 7'd6;
    localparam logic [SPEED_W-1:0] RST_SPEED_LEVEL   = 7'd30;

    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_KIND   = 5'b00010,
        PH_BUTTON = 5'b00100,
        PH_HIT    = 5'b01000,
        PH_CHECK  = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [DIST_W-1:0]  stop_distance;
        logic [STEP_W-1:0]  speed_step;
        logic [SPEED_W-1:0] speed_ceiling;
        logic [SPEED_W-1:0] speed_floor;
    } t_cfg;

    typedef struct packed {
        logic               mode;
        logic [BYTE_W-1:0]  rx_byte;
        logic [DIST_W-1:0]  distance_mm;
    } t_item;

    typedef struct packed {
        logic [SPEED_W-1:0] rear_drive;
        logic               lift_on;
        logic [STEER_W-1:0] steer;
        logic               board_leds;
        logic               lamp_leds;
        logic               horn_pulse;
        logic               is_moving;
        logic               is_blocked;
        logic [SPEED_W-1:0] speed_limit;
        logic               frame_accepted;
        logic               frame_rejected;
    } t_result;

endpackage

>>> rtl/rpcd_in_if.sv
// ----------------------------------------------------------------------------
// rpcd_in_if
// Input channel: a received serial byte or a range sample per beat.
// ----------------------------------------------------------------------------
interface rpcd_in_if;
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic [rpcd_pkg::BYTE_W-1:0]  rx_byte;
    logic [rpcd_pkg::DIST_W-1:0]  distance_mm;

    modport source (output valid, output mode, output rx_byte, output distance_mm,
                    input ready);
    modport sink   (input valid, input mode, input rx_byte, input distance_mm,
                    output ready);
endinterface

>>> rtl/rpcd_out_if.sv
// ----------------------------------------------------------------------------
// rpcd_out_if
// Result channel: one decoder status beat per input beat.
// ----------------------------------------------------------------------------
interface rpcd_out_if;
    logic                          valid;
    logic                          ready;
    logic [rpcd_pkg::SPEED_W-1:0]  rear_drive;
    logic                          lift_on;
    logic [rpcd_pkg::STEER_W-1:0]  steer;
    logic                          board_leds;
    logic                          lamp_leds;
    logic                          horn_pulse;
    logic                          is_moving;
    logic                          is_blocked;
    logic [rpcd_pkg::SPEED_W-1:0]  speed_limit;
    logic                          frame_accepted;
    logic                          frame_rejected;

    modport source (output valid, output rear_drive, output lift_on, output steer,
                    output board_leds, output lamp_leds, output horn_pulse,
                    output is_moving, output is_blocked, output speed_limit,
                    output frame_accepted, output frame_rejected, input ready);
    modport sink   (input valid, input rear_drive, input lift_on, input steer,
                    input board_leds, input lamp_leds, input horn_pulse,
                    input is_moving, input is_blocked, input speed_limit,
                    input frame_accepted, input frame_rejected, output ready);
endinterface

>>> rtl/rpcd_step.sv
// ----------------------------------------------------------------------------
// rpcd_step
// Decoder state and its single-pass update: range blocking, the five-byte
// button frame parser and the button actions.
// ----------------------------------------------------------------------------
module rpcd_step (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  rpcd_pkg::t_item   i_item,
    input  rpcd_pkg::t_cfg    i_cfg,
    output rpcd_pkg::t_result o_result
);

    rpcd_pkg::t_phase                r_phase,       n_phase;
    logic [rpcd_pkg::BYTE_W-1:0]     r_held_button, n_held_button;
    logic [rpcd_pkg::BYTE_W-1:0]     r_held_hit,    n_held_hit;
    logic [rpcd_pkg::SPEED_W-1:0]    r_speed,       n_speed;
    logic                            r_moving,      n_moving;
    logic                            r_blocked,     n_blocked;
    logic [rpcd_pkg::SPEED_W-1:0]    r_rear,        n_rear;
    logic [rpcd_pkg::STEER_W-1:0]    r_steer,       n_steer;
    logic                            r_board_led,   n_board_led;
    logic                            r_lamp,        n_lamp;

    logic [rpcd_pkg::BYTE_W-1:0]     w_check;
    logic [rpcd_pkg::SPEED_W:0]      w_up_sum;
    logic [rpcd_pkg::SPEED_W-1:0]    w_step;
    logic                            w_press;
    logic                            w_horn;
    logic                            w_acc;
    logic                            w_rej;

    assign w_check  = ~(rpcd_pkg::CH_START + rpcd_pkg::CH_KIND + r_held_button + r_held_hit);
    assign w_step   = {1'b0, i_cfg.speed_step};
    assign w_up_sum = {1'b0, r_speed} + {1'b0, w_step};
    assign w_press  = (r_held_hit == rpcd_pkg::CH_PRESS);

    always_comb begin
        n_phase       = r_phase;
        n_held_button = r_held_button;
        n_held_hit    = r_held_hit;
        n_speed       = r_speed;
        n_moving      = r_moving;
        n_blocked     = r_blocked;
        n_rear        = r_rear;
        n_steer       = r_steer;
        n_board_led   = r_board_led;
        n_lamp        = r_lamp;
        w_horn        = 1'b0;
        w_acc         = 1'b0;
        w_rej         = 1'b0;

        if (i_item.mode) begin
            if (i_item.distance_mm < i_cfg.stop_distance) begin
                n_blocked = 1'b1;
                n_rear    = '0;
                n_steer   = rpcd_pkg::STEER_CENTRE;
                n_moving  = 1'b0;
                n_phase   = rpcd_pkg::PH_IDLE;
            end else begin
                n_blocked = 1'b0;
            end
        end else if (!r_blocked) begin
            case (r_phase)
                rpcd_pkg::PH_KIND: begin
                    n_phase = (i_item.rx_byte == rpcd_pkg::CH_KIND) ? rpcd_pkg::PH_BUTTON
                                                                    : rpcd_pkg::PH_IDLE;
                end
                rpcd_pkg::PH_BUTTON: begin
                    n_held_button = i_item.rx_byte;
                    n_phase       = rpcd_pkg::PH_HIT;
                end
                rpcd_pkg::PH_HIT: begin
                    n_held_hit = i_item.rx_byte;
                    n_phase    = rpcd_pkg::PH_CHECK;
                end
                rpcd_pkg::PH_CHECK: begin
                    n_phase = rpcd_pkg::PH_IDLE;
                    if (i_item.rx_byte == w_check) begin
                        w_acc = 1'b1;
                        case (r_held_button)
                            rpcd_pkg::BTN_UP: begin
                                if (w_press) begin
                                    if (r_speed < i_cfg.speed_ceiling) begin
                                        n_speed = (w_up_sum > {1'b0, rpcd_pkg::SPEED_MAX})
                                                ? rpcd_pkg::SPEED_MAX
                                                : w_up_sum[rpcd_pkg::SPEED_W-1:0];
                                    end
                                end else if (r_moving) begin
                                    n_rear = r_speed;
                                end
                            end
                            rpcd_pkg::BTN_DOWN: begin
                                if (w_press) begin
                                    if (r_speed > i_cfg.speed_floor) begin
                                        n_speed = (r_speed > w_step) ? r_speed - w_step : '0;
                                    end
                                end else if (r_moving) begin
                                    n_rear = r_speed;
                                end
                            end
                            rpcd_pkg::BTN_LAMP: begin
                                if (w_press) n_lamp = ~r_lamp;
                            end
                            rpcd_pkg::BTN_HORN: begin
                                if (w_press) begin
                                    w_horn      = 1'b1;
                                    n_board_led = ~r_board_led;
                                end
                            end
                            rpcd_pkg::BTN_FORWARD: begin
                                n_rear   = w_press ? r_speed : '0;
                                n_moving = w_press;
                            end
                            rpcd_pkg::BTN_LEFT: begin
                                n_steer = w_press ? rpcd_pkg::STEER_LEFT
                                                  : rpcd_pkg::STEER_CENTRE;
                            end
                            rpcd_pkg::BTN_RIGHT: begin
                                n_steer = w_press ? rpcd_pkg::STEER_RIGHT
                                                  : rpcd_pkg::STEER_CENTRE;
                            end
                            default: ;
                        endcase
                    end else begin
                        w_rej = 1'b1;
                    end
                end
                default: begin
                    n_phase = (i_item.rx_byte == rpcd_pkg::CH_START) ? rpcd_pkg::PH_KIND
                                                                     : rpcd_pkg::PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= rpcd_pkg::PH_IDLE;
            r_held_button <= '0;
            r_held_hit    <= '0;
            r_speed       <= rpcd_pkg::RST_SPEED_LEVEL;
            r_moving      <= 1'b0;
            r_blocked     <= 1'b0;
            r_rear        <= '0;
            r_steer       <= rpcd_pkg::STEER_CENTRE;
            r_board_led   <= 1'b0;
            r_lamp        <= 1'b0;
        end else if (i_adv) begin
            r_phase       <= n_phase;
            r_held_button <= n_held_button;
            r_held_hit    <= n_held_hit;
            r_speed       <= n_speed;
            r_moving      <= n_moving;
            r_blocked     <= n_blocked;
            r_rear        <= n_rear;
            r_steer       <= n_steer;
            r_board_led   <= n_board_led;
            r_lamp        <= n_lamp;
        end
    end

    always_comb begin
        o_result.rear_drive     = n_rear;
        o_result.lift_on        = ~n_blocked;
        o_result.steer          = n_steer;
        o_result.board_leds     = n_board_led;
        o_result.lamp_leds      = n_lamp;
        o_result.horn_pulse     = w_horn;
        o_result.is_moving      = n_moving;
        o_result.is_blocked     = n_blocked;
        o_result.speed_limit    = n_speed;
        o_result.frame_accepted = w_acc;
        o_result.frame_rejected = w_rej;
    end

endmodule

>>> rtl/remote_pad_command_decoder_core.sv
// ----------------------------------------------------------------------------
// remote_pad_command_decoder_core
// Takes one beat per cycle while the result is not stalled, either a
// received serial byte or a range sample, and returns one status beat for
// each. A beat is latched in an input register, the decoder state is
// updated in one pass of logic, and the status is held in a result
// register; the single-pass update of the decoder state sets that rate.
// A stalled result holds the input register, so both sides can
// back-pressure freely. Configuration registers are written through a
// plain write port; the user must write them only while no beat is in
// flight, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module remote_pad_command_decoder_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    rpcd_in_if.sink                             i_item,
    rpcd_out_if.source                          o_result,
    input  logic                                i_cfg_we,
    input  logic [rpcd_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [rpcd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    rpcd_pkg::t_cfg     r_cfg;
    logic               r_in_valid;
    rpcd_pkg::t_item    r_in_item;
    logic               r_out_valid;
    rpcd_pkg::t_result  r_out;
    rpcd_pkg::t_result  w_next;
    logic               w_adv;
    logic               w_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stop_distance <= rpcd_pkg::RST_STOP_DISTANCE;
            r_cfg.speed_step    <= rpcd_pkg::RST_SPEED_STEP;
            r_cfg.speed_ceiling <= rpcd_pkg::RST_SPEED_CEILING;
            r_cfg.speed_floor   <= rpcd_pkg::RST_SPEED_FLOOR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rpcd_pkg::CFG_STOP_DISTANCE: r_cfg.stop_distance <= i_cfg_wdata;
                rpcd_pkg::CFG_SPEED_STEP:
                    r_cfg.speed_step <= i_cfg_wdata[rpcd_pkg::STEP_W-1:0];
                rpcd_pkg::CFG_SPEED_CEILING:
                    r_cfg.speed_ceiling <= i_cfg_wdata[rpcd_pkg::SPEED_W-1:0];
                rpcd_pkg::CFG_SPEED_FLOOR:
                    r_cfg.speed_floor <= i_cfg_wdata[rpcd_pkg::SPEED_W-1:0];
                default: ;
            endcase
        end
    end

    // advance the input beat into the result register when it has room
    assign w_adv        = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_adv;
    assign w_take       = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_item.mode        <= i_item.mode;
            r_in_item.rx_byte     <= i_item.rx_byte;
            r_in_item.distance_mm <= i_item.distance_mm;
        end
    end

    rpcd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (w_adv),
        .i_item   (r_in_item),
        .i_cfg    (r_cfg),
        .o_result (w_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= w_next;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.rear_drive     = r_out.rear_drive;
    assign o_result.lift_on        = r_out.lift_on;
    assign o_result.steer          = r_out.steer;
    assign o_result.board_leds     = r_out.board_leds;
    assign o_result.lamp_leds      = r_out.lamp_leds;
    assign o_result.horn_pulse     = r_out.horn_pulse;
    assign o_result.is_moving      = r_out.is_moving;
    assign o_result.is_blocked     = r_out.is_blocked;
    assign o_result.speed_limit    = r_out.speed_limit;
    assign o_result.frame_accepted = r_out.frame_accepted;
    assign o_result.frame_rejected = r_out.frame_rejected;

    a_lift_follows_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.lift_on != o_result.is_blocked))
        else $error("lift_on does not mirror the blocked flag");

    a_accept_reject_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> !(o_result.frame_accepted && o_result.frame_rejected))
        else $error("frame both accepted and rejected");

    a_horn_needs_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.horn_pulse) |-> o_result.frame_accepted)
        else $error("horn pulse without an accepted frame");

    a_blocked_stops_drive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.is_blocked) |->
            (o_result.rear_drive == '0 && !o_result.is_moving &&
             o_result.steer == rpcd_pkg::STEER_CENTRE))
        else $error("drive active while blocked");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_adv) |=> (r_in_valid && $stable(r_in_item)))
        else $error("pending input beat lost during a result stall");

endmodule
